/* rtl/rbfe_pkg.sv */
package rbfe_pkg;

    // request codes
    localparam logic [1:0] REQ_PUT     = 2'd0;
    localparam logic [1:0] REQ_DEFRAME = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START_FLAG  = 2'd0;
    localparam logic [1:0] CFG_END_FLAG    = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd2;

    localparam logic [7:0] START_FLAG_RST  = 8'd2;
    localparam logic [7:0] END_FLAG_RST    = 8'd3;
    localparam logic [7:0] ESCAPE_BYTE_RST = 8'd16;

    localparam logic [6:0] MAX_READ = 7'd64;

    typedef logic [6:0] t_size;
    typedef logic [5:0] t_held;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_in;
        logic [6:0] count;
    } t_in;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        t_size      frame_size;
        t_held      stored_count;
        logic       last;
    } t_out;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic       we;
        logic [7:0] wdata;
        logic       tok_load;
        logic       tok_shift;
        logic [7:0] start_flag;
        logic [7:0] end_flag;
        logic [7:0] escape_byte;
    } t_cell_ctrl;

    // what a cell reports while it holds the token
    typedef struct packed {
        logic       tok;
        logic [7:0] rdata;
        logic       hit_start;
        logic       hit_end;
    } t_cell_stat;

endpackage

/* rtl/rbfe_cell.sv */
module rbfe_cell import rbfe_pkg::*; #(
    parameter int PW    = 6,
    parameter int INDEX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctrl    i_ctrl,
    input  logic [PW-1:0] i_wptr,
    input  logic [PW-1:0] i_tptr,
    input  logic          i_tok_prev,
    output t_cell_stat    o_stat
);

    localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

    logic [7:0] r_byte, n_byte;
    logic       r_tok, n_tok;
    logic       w_match_s, w_match_e;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.we && (i_wptr == MY_IDX)) begin
            n_byte = i_ctrl.wdata;
        end
        n_tok = r_tok;
        if (i_ctrl.tok_load) begin
            n_tok = (i_tptr == MY_IDX);
        end else if (i_ctrl.tok_shift) begin
            // pass the token on to the next cell
            n_tok = i_tok_prev;
        end
    end

    assign w_match_s = (r_byte == i_ctrl.start_flag) && (r_byte != i_ctrl.escape_byte);
    assign w_match_e = (r_byte == i_ctrl.end_flag) && (r_byte != i_ctrl.escape_byte);

    always_comb begin
        o_stat.tok       = r_tok;
        o_stat.rdata     = r_tok ? r_byte : 8'd0;
        o_stat.hit_start = r_tok && w_match_s;
        o_stat.hit_end   = r_tok && w_match_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
            r_tok  <= 1'b0;
        end else begin
            r_byte <= n_byte;
            r_tok  <= n_tok;
        end
    end

endmodule

/* rtl/ring_buffer_frame_extractor.sv */
// Put, clear or unused code: one result beat after the frame search, which walks a token
//   through one cell per cycle over the bytes held.
// Deframe of N bytes (N saturated to 64): one beat per cycle while the output is taken;
//   one item at a time.
// Reset (synchronous, active low): head and tail pointers and all ring bytes to zero, flags to
//   their defaults (start 2, end 3, escape 16), output empty.
module ring_buffer_frame_extractor import rbfe_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADV   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_ELOAD = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_STAT  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_head, n_head, r_tail, n_tail, r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_req, n_req;
    logic [6:0]    r_cnt, n_cnt, r_step, n_step;
    logic [PW-1:0] r_k, n_k, r_s_rel, n_s_rel, r_e_rel, n_e_rel;
    logic          r_got_s, n_got_s, r_got_e, n_got_e;
    logic [7:0]    r_start, n_start, r_end, n_end, r_esc, n_esc;
    logic          r_ov, n_ov;
    t_out          r_out, n_out;

    t_cell_ctrl    w_ctrl;
    logic [PW-1:0] w_tptr;
    t_cell_stat    w_stat [DEPTH];
    logic [7:0]    w_bus_rdata;
    logic          w_bus_hit_s, w_bus_hit_e;
    logic          w_in_acc, w_out_free, w_last;
    logic [PW-1:0] w_held;
    logic [PW:0]   w_diff;
    t_size         w_fsize;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            rbfe_cell #(
                .PW    (PW),
                .INDEX (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_wptr     (r_tail),
                .i_tptr     (w_tptr),
                .i_tok_prev (w_stat[(gi == 0) ? DEPTH - 1 : gi - 1].tok),
                .o_stat     (w_stat[gi])
            );
        end
    endgenerate

    // only the token holder drives a non-zero value
    always_comb begin
        w_bus_rdata = 8'd0;
        w_bus_hit_s = 1'b0;
        w_bus_hit_e = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_bus_rdata = w_bus_rdata | w_stat[i].rdata;
            w_bus_hit_s = w_bus_hit_s | w_stat[i].hit_start;
            w_bus_hit_e = w_bus_hit_e | w_stat[i].hit_end;
        end
    end

    always_comb begin
        if (r_head == r_tail) begin
            w_held = '0;
        end else if (r_head < r_tail) begin
            w_held = r_tail - r_head;
        end else begin
            w_held = PW'(DEPTH_W - {1'b0, r_head - r_tail});
        end
        if (r_e_rel >= r_s_rel) begin
            w_diff = {1'b0, r_e_rel - r_s_rel};
        end else begin
            w_diff = DEPTH_W - {1'b0, r_s_rel} + {1'b0, r_e_rel};
        end
        w_fsize = (r_got_s && r_got_e) ? t_size'(w_diff + 1'b1) : '0;
    end

    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_ov || i_ready;
    assign w_last     = ((r_step + 7'd1) == r_cnt);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_rd_ptr = r_rd_ptr;
        n_req    = r_req;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_k      = r_k;
        n_s_rel  = r_s_rel;
        n_e_rel  = r_e_rel;
        n_got_s  = r_got_s;
        n_got_e  = r_got_e;
        n_start  = r_start;
        n_end    = r_end;
        n_esc    = r_esc;
        n_ov     = r_ov;
        n_out    = r_out;
        w_tptr   = r_head;

        w_ctrl.we          = w_in_acc && (i_data.req_type == REQ_PUT);
        w_ctrl.wdata       = i_data.byte_in;
        w_ctrl.tok_load    = 1'b0;
        w_ctrl.tok_shift   = 1'b0;
        w_ctrl.start_flag  = r_start;
        w_ctrl.end_flag    = r_end;
        w_ctrl.escape_byte = r_esc;

        if (i_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_req = i_data.req_type;
                    case (i_data.req_type)
                        REQ_PUT: begin
                            n_tail = wrap_inc(r_tail);
                        end
                        REQ_CLEAR: begin
                            n_head = '0;
                            n_tail = '0;
                        end
                        default: begin
                        end
                    endcase
                    if (i_data.req_type == REQ_DEFRAME) begin
                        n_rd_ptr = r_head;
                        n_cnt    = (i_data.count > MAX_READ) ? MAX_READ : i_data.count;
                        n_step   = 7'd0;
                        n_state  = ST_ADV;
                    end else begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_ADV: begin
                // advance the head one byte a cycle; it may wrap past the last cell
                if (r_step == r_cnt) begin
                    n_state = ST_LOAD;
                end else begin
                    n_head = wrap_inc(r_head);
                    n_step = r_step + 7'd1;
                end
            end
            ST_LOAD: begin
                w_ctrl.tok_load = 1'b1;
                w_tptr  = r_head;
                n_k     = '0;
                n_got_s = 1'b0;
                n_got_e = 1'b0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_k == w_held) begin
                    n_state = ((r_req == REQ_DEFRAME) && (r_cnt != 7'd0)) ? ST_ELOAD : ST_STAT;
                end else begin
                    w_ctrl.tok_shift = 1'b1;
                    // keep the first match of each flag
                    if (!r_got_s && w_bus_hit_s) begin
                        n_got_s = 1'b1;
                        n_s_rel = r_k;
                    end
                    if (!r_got_e && w_bus_hit_e) begin
                        n_got_e = 1'b1;
                        n_e_rel = r_k;
                    end
                    n_k = r_k + 1'b1;
                end
            end
            ST_ELOAD: begin
                w_ctrl.tok_load = 1'b1;
                w_tptr  = r_rd_ptr;
                n_step  = 7'd0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ov                 = 1'b1;
                    n_out.byte_out       = w_bus_rdata;
                    n_out.byte_valid     = 1'b1;
                    n_out.frame_size     = w_fsize;
                    n_out.stored_count   = t_held'(w_held);
                    n_out.last           = w_last;
                    w_ctrl.tok_shift     = 1'b1;
                    n_step               = r_step + 7'd1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_STAT: begin
                if (w_out_free) begin
                    n_ov               = 1'b1;
                    n_out.byte_out     = 8'd0;
                    n_out.byte_valid   = 1'b0;
                    n_out.frame_size   = w_fsize;
                    n_out.stored_count = t_held'(w_held);
                    n_out.last         = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_START_FLAG:  n_start = i_cfg_wdata;
                CFG_END_FLAG:    n_end   = i_cfg_wdata;
                CFG_ESCAPE_BYTE: n_esc   = i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_got_s <= 1'b0;
            r_got_e <= 1'b0;
            r_start <= START_FLAG_RST;
            r_end   <= END_FLAG_RST;
            r_esc   <= ESCAPE_BYTE_RST;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_got_s <= n_got_s;
            r_got_e <= n_got_e;
            r_start <= n_start;
            r_end   <= n_end;
            r_esc   <= n_esc;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_req    <= n_req;
        r_cnt    <= n_cnt;
        r_step   <= n_step;
        r_k      <= n_k;
        r_s_rel  <= n_s_rel;
        r_e_rel  <= n_e_rel;
        r_out    <= n_out;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule
